[rtl/core/mec_pkg.sv]
// mec_pkg: shared widths, register indexes, reset values, types and palette
// for the escape-time colorizer core; depends on nothing
package mec_pkg;

    localparam int PixW     = 12;
    localparam int CoordW   = 32;
    localparam int StepW    = 31;
    localparam int IterW    = 16;
    localparam int ColorW   = 8;
    localparam int ProdW    = 64;
    localparam int FracBits = 28;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_REAL_MIN  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_IMAG_MIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_REAL_STEP = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_IMAG_STEP = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MAX_ITER  = 3'd4;

    localparam logic signed [CoordW-1:0] RST_REAL_MIN  = -32'sd50465866;
    localparam logic signed [CoordW-1:0] RST_IMAG_MIN  = 32'sd148713243;
    localparam logic [StepW-1:0]         RST_REAL_STEP = 31'd11534;
    localparam logic [StepW-1:0]         RST_IMAG_STEP = 31'd13107;
    localparam logic [IterW-1:0]         RST_MAX_ITER  = 16'd200;

    // 4.0 in q4.28
    localparam logic [CoordW-1:0] ESCAPE_LIMIT = 32'h4000_0000;
    localparam logic [StepW-1:0]  SQ_MAX       = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [CoordW-1:0] real_min;
        logic signed [CoordW-1:0] imag_min;
        logic [StepW-1:0]         real_step;
        logic [StepW-1:0]         imag_step;
        logic [IterW-1:0]         max_iter;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic [IterW-1:0] count;
    } eng_res_t;

    typedef struct packed {
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
    } rgb_t;

    localparam rgb_t INSIDE_RGB = '{red: 8'd16, green: 8'd16, blue: 8'd16};

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [ProdW-1:0] v);
        logic signed [CoordW-1:0] r;
        if (v > $signed(64'sh0000_0000_7FFF_FFFF))
            r = 32'sh7FFF_FFFF;
        else if (v < $signed(64'shFFFF_FFFF_8000_0000))
            r = 32'sh8000_0000;
        else
            r = v[CoordW-1:0];
        return r;
    endfunction

    function automatic rgb_t palette(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:  c = '{8'd66,  8'd30,  8'd15};
            4'd1:  c = '{8'd25,  8'd7,   8'd26};
            4'd2:  c = '{8'd9,   8'd1,   8'd47};
            4'd3:  c = '{8'd4,   8'd4,   8'd73};
            4'd4:  c = '{8'd0,   8'd7,   8'd100};
            4'd5:  c = '{8'd12,  8'd44,  8'd138};
            4'd6:  c = '{8'd24,  8'd82,  8'd177};
            4'd7:  c = '{8'd57,  8'd125, 8'd209};
            4'd8:  c = '{8'd134, 8'd181, 8'd229};
            4'd9:  c = '{8'd211, 8'd236, 8'd248};
            4'd10: c = '{8'd241, 8'd233, 8'd191};
            4'd11: c = '{8'd248, 8'd201, 8'd95};
            4'd12: c = '{8'd255, 8'd170, 8'd0};
            4'd13: c = '{8'd204, 8'd128, 8'd0};
            4'd14: c = '{8'd153, 8'd87,  8'd0};
            default: c = '{8'd106, 8'd52, 8'd3};
        endcase
        return c;
    endfunction

endpackage

[rtl/core/mec_pixel_if.sv]
// mec_pixel_if: valid/ready channel carrying one pixel coordinate word
// depends on mec_pkg
interface mec_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [mec_pkg::PixW-1:0]  pixel_x;
    logic [mec_pkg::PixW-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[rtl/core/mec_color_if.sv]
// mec_color_if: valid/ready channel carrying one colored result word
// depends on mec_pkg
interface mec_color_if;
    logic                        valid;
    logic                        ready;
    logic [mec_pkg::ColorW-1:0]  red;
    logic [mec_pkg::ColorW-1:0]  green;
    logic [mec_pkg::ColorW-1:0]  blue;
    logic [mec_pkg::IterW-1:0]   iterations;

    modport source (output valid, output red, output green, output blue,
                    output iterations, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input iterations, output ready);
endinterface

[rtl/core/mec_mult.sv]
// mec_mult: shared signed 32x32 multiplier with registered 64 bit product
// depends on mec_pkg
module mec_mult (
    input  logic                               clk,
    input  logic signed [mec_pkg::CoordW-1:0]  a,
    input  logic signed [mec_pkg::CoordW-1:0]  b,
    output logic signed [mec_pkg::ProdW-1:0]   p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

[rtl/core/mec_engine.sv]
// mec_engine: sequencer for coordinate setup and z = z^2 + c iteration
// depends on mec_pkg and mec_mult
module mec_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mec_pkg::PixW-1:0]      pixel_x,
    input  logic [mec_pkg::PixW-1:0]      pixel_y,
    input  mec_pkg::cfg_t                 cfg,
    input  logic                          take,
    output mec_pkg::eng_res_t             res,
    output logic                          idle
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CR    = 4'd1;
    localparam logic [3:0] S_CI    = 4'd2;
    localparam logic [3:0] S_SNAP  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_CROSS = 4'd5;
    localparam logic [3:0] S_SQR   = 4'd6;
    localparam logic [3:0] S_SQI   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [mec_pkg::PixW-1:0]          px_reg, py_reg;
    logic signed [mec_pkg::CoordW-1:0] cr_reg, ci_reg, zr_reg, zi_reg;
    logic [mec_pkg::StepW-1:0]         sqr_reg, sqi_reg;
    logic [mec_pkg::IterW-1:0]         count_reg;

    logic signed [mec_pkg::CoordW-1:0] mul_a, mul_b;
    logic signed [mec_pkg::ProdW-1:0]  p_reg;

    logic signed [mec_pkg::CoordW-1:0] coord_base, coord;
    logic [mec_pkg::CoordW:0]          ci_mag;
    logic                              snap;
    logic signed [mec_pkg::CoordW-1:0] zr_new, zi_new;
    logic [mec_pkg::ProdW-1:0]         sq_wide;
    logic [mec_pkg::StepW-1:0]         sq_sat;
    logic [mec_pkg::CoordW-1:0]        mag_sum;
    logic                              cont;

    mec_mult u_mult (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (p_reg)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CR:
            begin
                mul_a = $signed({20'd0, px_reg});
                mul_b = $signed({1'b0, cfg.real_step});
            end
            S_CI:
            begin
                mul_a = $signed({20'd0, py_reg});
                mul_b = $signed({1'b0, cfg.imag_step});
            end
            S_CHECK:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            S_CROSS:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_SQR:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        coord_base = (state_reg == S_CI) ? cfg.real_min : cfg.imag_min;
        coord      = mec_pkg::sat32(64'(coord_base) + p_reg);
        ci_mag     = coord[mec_pkg::CoordW-1] ? (33'd0 - 33'(coord)) : 33'(coord);
        snap       = ({ci_mag, 1'b0} < {3'd0, cfg.imag_step});

        zr_new  = mec_pkg::sat32(64'($signed({1'b0, sqr_reg}))
                                 - 64'($signed({1'b0, sqi_reg}))
                                 + 64'(cr_reg));
        zi_new  = mec_pkg::sat32((p_reg >>> (mec_pkg::FracBits - 1)) + 64'(ci_reg));

        sq_wide = 64'(p_reg) >> mec_pkg::FracBits;
        sq_sat  = (sq_wide > 64'(mec_pkg::SQ_MAX)) ? mec_pkg::SQ_MAX
                                                  : sq_wide[mec_pkg::StepW-1:0];

        mag_sum = {1'b0, sqr_reg} + {1'b0, sqi_reg};
        cont    = (count_reg < cfg.max_iter) && (mag_sum < mec_pkg::ESCAPE_LIMIT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_CR;
            S_CR:    state_next = S_CI;
            S_CI:    state_next = S_SNAP;
            S_SNAP:  state_next = S_CHECK;
            S_CHECK: state_next = cont ? S_CROSS : S_DONE;
            S_CROSS: state_next = S_SQR;
            S_SQR:   state_next = S_SQI;
            S_SQI:   state_next = S_CHECK;
            S_DONE:  if (take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (state_reg == S_CI)
            cr_reg <= coord;
        if (state_reg == S_SNAP)
        begin
            ci_reg    <= snap ? '0 : coord;
            zr_reg    <= '0;
            zi_reg    <= '0;
            sqr_reg   <= '0;
            sqi_reg   <= '0;
            count_reg <= '0;
        end
        if (state_reg == S_CHECK && cont)
            zr_reg <= zr_new;
        if (state_reg == S_CROSS)
            zi_reg <= zi_new;
        if (state_reg == S_SQR)
        begin
            sqr_reg   <= sq_sat;
            count_reg <= count_reg + 16'd1;
        end
        if (state_reg == S_SQI)
            sqi_reg <= sq_sat;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res.done   = (state_reg == S_DONE);
    assign res.count  = count_reg;

endmodule

[rtl/core/mandelbrot_escape_time_colorizer_core.sv]
// mandelbrot_escape_time_colorizer_core: top level with config registers,
// pixel and color channels, palette lookup; depends on mec_pkg, mec_engine,
// mec_pixel_if and mec_color_if
//
// channel  | dir | word
// ---------+-----+-------------------------------------------
// pixel    | in  | pixel_x, pixel_y (12 bit each)
// color    | out | red, green, blue (8 bit each), iterations (16 bit)
// cfg      | in  | cfg_we, cfg_index (3 bit), cfg_data (32 bit)
//
// a word runs coordinate setup, then N iterations, then S_DONE; N = iterations
// all products go through one 32x32 multiplier: two for the coordinate, three
// per iteration; pixel.ready is high only while the sequencer is idle
// the output register holds one finished word so a new pixel can be taken
// while color is stalled; reset loads the default view and limit 200
module mandelbrot_escape_time_colorizer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mec_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [mec_pkg::CfgDataW-1:0]      cfg_data,
    mec_pixel_if.sink                         pixel,
    mec_color_if.source                       color
);

    mec_pkg::cfg_t     cfg_reg;
    mec_pkg::eng_res_t res;
    mec_pkg::rgb_t     rgb_reg, rgb_next;
    logic              idle;
    logic              take;
    logic              out_valid_reg;
    logic [mec_pkg::IterW-1:0] iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_min  <= mec_pkg::RST_REAL_MIN;
            cfg_reg.imag_min  <= mec_pkg::RST_IMAG_MIN;
            cfg_reg.real_step <= mec_pkg::RST_REAL_STEP;
            cfg_reg.imag_step <= mec_pkg::RST_IMAG_STEP;
            cfg_reg.max_iter  <= mec_pkg::RST_MAX_ITER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mec_pkg::REG_REAL_MIN:  cfg_reg.real_min  <= $signed(cfg_data);
                mec_pkg::REG_IMAG_MIN:  cfg_reg.imag_min  <= $signed(cfg_data);
                mec_pkg::REG_REAL_STEP: cfg_reg.real_step <= cfg_data[mec_pkg::StepW-1:0];
                mec_pkg::REG_IMAG_STEP: cfg_reg.imag_step <= cfg_data[mec_pkg::StepW-1:0];
                mec_pkg::REG_MAX_ITER:  cfg_reg.max_iter  <= cfg_data[mec_pkg::IterW-1:0];
                default: ;
            endcase
        end
    end

    mec_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pixel.valid && idle),
        .pixel_x (pixel.pixel_x),
        .pixel_y (pixel.pixel_y),
        .cfg     (cfg_reg),
        .take    (take),
        .res     (res),
        .idle    (idle)
    );

    assign pixel.ready = idle;
    assign take        = res.done && (!out_valid_reg || color.ready);

    always_comb
    begin
        if (res.count == cfg_reg.max_iter)
            rgb_next = mec_pkg::INSIDE_RGB;
        else
            rgb_next = mec_pkg::palette(res.count[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (color.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rgb_reg  <= rgb_next;
            iter_reg <= res.count;
        end
    end

    assign color.valid      = out_valid_reg;
    assign color.red        = rgb_reg.red;
    assign color.green      = rgb_reg.green;
    assign color.blue       = rgb_reg.blue;
    assign color.iterations = iter_reg;

endmodule

[test/mandelbrot_escape_time_colorizer_core_tb.sv]
`timescale 1ns / 1ps
// testbench for mandelbrot_escape_time_colorizer_core: drives pixel words, predicts
// the escape count and color in q4.28, checks every color word in order
// depends on mec_pkg, mec_pixel_if, mec_color_if and the core

module mandelbrot_escape_time_colorizer_core_tb;

    localparam int     LONG_STALL = 2500;
    localparam longint Q_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN      = -64'sh0000_0000_8000_0000;

    // indexes with no register behind them
    localparam logic [mec_pkg::CfgIdxW-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [mec_pkg::CfgIdxW-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [3*mec_pkg::ColorW-1:0] GRADIENT [16] = '{
        24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
        24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
        24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
        24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
    };

    typedef enum int {VIEW_OVERVIEW, VIEW_ZOOM, VIEW_WILD, VIEW_ESCAPE} view_kind_t;

    typedef struct packed {
        logic [mec_pkg::PixW-1:0] x;
        logic [mec_pkg::PixW-1:0] y;
    } pixel_word_t;

    typedef struct packed {
        logic [mec_pkg::PixW-1:0]  x;
        logic [mec_pkg::PixW-1:0]  y;
        mec_pkg::rgb_t             rgb;
        logic [mec_pkg::IterW-1:0] count;
    } color_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [mec_pkg::CfgIdxW-1:0]  cfg_index;
    logic [mec_pkg::CfgDataW-1:0] cfg_data;

    mec_pixel_if pixel_bus ();
    mec_color_if color_bus ();

    mandelbrot_escape_time_colorizer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_bus),
        .color     (color_bus)
    );

    // copy of the view registers
    logic signed [mec_pkg::CoordW-1:0] view_re0   = mec_pkg::RST_REAL_MIN;
    logic signed [mec_pkg::CoordW-1:0] view_im0   = mec_pkg::RST_IMAG_MIN;
    logic [mec_pkg::StepW-1:0]         step_re    = mec_pkg::RST_REAL_STEP;
    logic [mec_pkg::StepW-1:0]         step_im    = mec_pkg::RST_IMAG_STEP;
    logic [mec_pkg::IterW-1:0]         iter_limit = mec_pkg::RST_MAX_ITER;

    pixel_word_t pending_pixels [$];
    color_word_t pending_colors [$];
    color_word_t oldest;

    logic pix_fire       = 1'b0;
    logic color_fire     = 1'b0;
    bit   offering       = 1'b0;
    bit   no_idle        = 1'b0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    int   stall_left     = 0;
    int   stalls_ordered = 0;
    int   stalls_served  = 0;
    int   mismatch_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clip_coord(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    function automatic longint square_clip(input longint v);
        longint s;
        s = (v * v) >>> mec_pkg::FracBits;
        if (s > Q_MAX)
            s = Q_MAX;
        return s;
    endfunction

    function automatic color_word_t escape_color(input logic [mec_pkg::PixW-1:0] px,
                                                 input logic [mec_pkg::PixW-1:0] py);
        longint      c_re;
        longint      c_im;
        longint      z_re;
        longint      z_im;
        longint      sq_re;
        longint      sq_im;
        longint      cross_term;
        longint      mag;
        int unsigned n;
        color_word_t w;
        c_re = clip_coord(longint'(view_re0) + longint'(px) * longint'(step_re));
        c_im = clip_coord(longint'(view_im0) + longint'(py) * longint'(step_im));
        mag = (c_im < 0) ? -c_im : c_im;
        // rows within half a step of the axis sit on it
        if (2 * mag < longint'(step_im))
            c_im = 0;
        z_re = 0;
        z_im = 0;
        sq_re = 0;
        sq_im = 0;
        n = 0;
        while (n < iter_limit && sq_re + sq_im < longint'(mec_pkg::ESCAPE_LIMIT))
        begin
            cross_term = (z_re * z_im) >>> (mec_pkg::FracBits - 1);
            z_im = clip_coord(cross_term + c_im);
            z_re = clip_coord(sq_re - sq_im + c_re);
            sq_re = square_clip(z_re);
            sq_im = square_clip(z_im);
            n++;
        end
        w.x = px;
        w.y = py;
        w.count = n[mec_pkg::IterW-1:0];
        if (n == iter_limit)
            w.rgb = mec_pkg::INSIDE_RGB;
        else
            w.rgb = GRADIENT[n[3:0]];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        mismatch_count++;
        $display("mismatch %s: got %0d, expected %0d, pixel (%0d, %0d)",
                 what, got, wanted, oldest.x, oldest.y);
    endtask

    // monitor: predicts on each pixel word taken, checks each color word
    always @(posedge clk)
    begin
        pix_fire   <= rst_n && pixel_bus.valid && pixel_bus.ready;
        color_fire <= rst_n && color_bus.valid && color_bus.ready;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
            pending_colors.push_back(escape_color(pixel_bus.pixel_x, pixel_bus.pixel_y));
        if (rst_n && color_bus.valid && color_bus.ready)
        begin
            if (pending_colors.size() == 0)
            begin
                report_mismatch("color word with no pixel pending", color_bus.iterations, 0);
            end
            else
            begin
                oldest = pending_colors.pop_front();
                if (color_bus.red !== oldest.rgb.red)
                    report_mismatch("red", color_bus.red, oldest.rgb.red);
                if (color_bus.green !== oldest.rgb.green)
                    report_mismatch("green", color_bus.green, oldest.rgb.green);
                if (color_bus.blue !== oldest.rgb.blue)
                    report_mismatch("blue", color_bus.blue, oldest.rgb.blue);
                if (color_bus.iterations !== oldest.count)
                    report_mismatch("iterations", color_bus.iterations, oldest.count);
            end
        end
    end

    // pixel driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pixel_bus.valid <= 1'b0;
        end
        else
        begin
            if (pix_fire)
            begin
                void'(pending_pixels.pop_front());
                offering = 1'b0;
                send_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_pixels.size() != 0)
                    offering = 1'b1;
            end
            pixel_bus.valid <= offering;
            if (offering)
            begin
                pixel_bus.pixel_x <= pending_pixels[0].x;
                pixel_bus.pixel_y <= pending_pixels[0].y;
            end
        end
    end

    // color receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            color_bus.ready <= 1'b0;
        end
        else
        begin
            if (color_fire)
                recv_gap = no_idle ? 0 : $urandom_range(0, 9);
            if (stalls_served != stalls_ordered)
            begin
                stalls_served = stalls_ordered;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                color_bus.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                color_bus.ready <= 1'b0;
            end
            else
            begin
                color_bus.ready <= 1'b1;
            end
        end
    end

    task automatic set_register(input logic [mec_pkg::CfgIdxW-1:0] idx,
                                input logic [mec_pkg::CfgDataW-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mec_pkg::REG_REAL_MIN:  view_re0 = value;
            mec_pkg::REG_IMAG_MIN:  view_im0 = value;
            mec_pkg::REG_REAL_STEP: step_re = value[mec_pkg::StepW-1:0];
            mec_pkg::REG_IMAG_STEP: step_im = value[mec_pkg::StepW-1:0];
            mec_pkg::REG_MAX_ITER:  iter_limit = value[mec_pkg::IterW-1:0];
            default: ;
        endcase
    endtask

    task automatic program_view(input logic [mec_pkg::CfgDataW-1:0] re0,
                                input logic [mec_pkg::CfgDataW-1:0] im0,
                                input logic [mec_pkg::CfgDataW-1:0] sre,
                                input logic [mec_pkg::CfgDataW-1:0] sim,
                                input logic [mec_pkg::CfgDataW-1:0] lim);
        set_register(mec_pkg::REG_REAL_MIN, re0);
        set_register(mec_pkg::REG_IMAG_MIN, im0);
        set_register(mec_pkg::REG_REAL_STEP, sre);
        set_register(mec_pkg::REG_IMAG_STEP, sim);
        set_register(mec_pkg::REG_MAX_ITER, lim);
    endtask

    task automatic program_family(input view_kind_t kind, input bit full_limit);
        int lim;
        case (kind)
            VIEW_OVERVIEW:
                program_view(-671088640 + int'($urandom_range(0, 1 << 25)) - (1 << 24),
                             -335544320 + int'($urandom_range(0, 1 << 24)) - (1 << 23),
                             $urandom_range(120000, 240000), $urandom_range(80000, 170000),
                             $urandom_range(1, 64));
            // around the neck at -0.75
            VIEW_ZOOM:
                program_view(-201326592 + int'($urandom_range(0, 1 << 23)) - (1 << 22),
                             33554432 + int'($urandom_range(0, 1 << 23)) - (1 << 22),
                             $urandom_range(0, 4096), $urandom_range(0, 4096),
                             $urandom_range(16, 100));
            VIEW_WILD:
            begin
                lim = $urandom_range(0, 40);
                program_view($urandom, $urandom, $urandom, $urandom,
                             {16'($urandom), 16'(lim)});
            end
            // real part at least 1.0 so every point escapes in a few rounds
            default:
                program_view($urandom_range(32'h1000_0000, 32'h7FFF_FFFF), $urandom,
                             $urandom_range(0, 1 << 20), $urandom,
                             full_limit ? 32'h0000_FFFF : $urandom_range(40000, 65535));
        endcase
    endtask

    task automatic queue_pixel(input logic [mec_pkg::PixW-1:0] x,
                               input logic [mec_pkg::PixW-1:0] y);
        pending_pixels.push_back({x, y});
    endtask

    function automatic logic [mec_pkg::PixW-1:0] pick_coord();
        int unsigned r;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? {mec_pkg::PixW{1'b1}} : {mec_pkg::PixW{1'b0}};
        r = $urandom_range(0, (1 << mec_pkg::PixW) - 1);
        return r[mec_pkg::PixW-1:0];
    endfunction

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++)
            queue_pixel(pick_coord(), pick_coord());
    endtask

    task automatic wait_for_drain();
        while (pending_pixels.size() != 0 || pending_colors.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_bus.valid = 1'b0;
        pixel_bus.pixel_x = '0;
        pixel_bus.pixel_y = '0;
        color_bus.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default view, field extremes
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd0, 12'd4095);
        queue_pixel(12'd4095, 12'd0);
        queue_pixel(12'd2048, 12'd2048);
        wait_for_drain();

        // zero limit gives the inside color at once
        set_register(mec_pkg::REG_MAX_ITER, 32'd0);
        queue_pixel(12'd17, 12'd300);
        queue_pixel(12'd4095, 12'd4095);
        wait_for_drain();

        // writes to unused indexes change nothing
        set_register(mec_pkg::REG_MAX_ITER, 32'd30);
        for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
            set_register(k[mec_pkg::CfgIdxW-1:0], $urandom);
        queue_pixel(12'd100, 12'd100);
        wait_for_drain();

        // snap to the real axis, just under and exactly at half a step
        program_view(32'sd1 <<< 26, -32'sd499, 32'd1024, 32'd1000, 32'd60);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd3, 12'd1);
        wait_for_drain();
        set_register(mec_pkg::REG_IMAG_MIN, -32'sd500);
        queue_pixel(12'd0, 12'd0);
        wait_for_drain();

        // coordinate saturation at both ends
        program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd1, 12'd1);
        queue_pixel(12'd2, 12'd3);
        wait_for_drain();
        program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1);
        queue_pixel(12'd4095, 12'd0);
        queue_pixel(12'd0, 12'd4095);
        wait_for_drain();

        // unit grid from -2: c = -2, -1, 0, 2 and 1+i
        program_view(-(32'sd1 <<< 29), 32'd0, 32'd1 << 28, 32'd1 << 28, 32'd200);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd1, 12'd0);
        queue_pixel(12'd2, 12'd0);
        queue_pixel(12'd4, 12'd0);
        queue_pixel(12'd3, 12'd1);
        wait_for_drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            wait_for_drain();
            program_family(view_kind_t'(phase % 4), phase == 3);
            no_idle = (phase == 5);
            if (phase == 4)
                stalls_ordered++;
            if (phase == 6)
            begin
                feed_random(60);
                wait_for_drain();
                feed_random(65);
            end
            else
            begin
                feed_random(125);
            end
        end

        wait_for_drain();
        no_idle = 1'b0;
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
